>>> src/qct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_pkg: shared types and constants of the quadrature count tracker
// Input and result word layouts, register indexes, sequencer states and the
// fixed-point scale factors used by the position and speed datapath.
// ----------------------------------------------------------------------------
package qct_pkg;

  // input word: raw counter value and elapsed time
  typedef struct packed {
    logic [15:0] raw_count;
    logic [19:0] dt_us;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] total_count;
    logic signed [47:0] position_deg_q8;
    logic signed [47:0] rpm_q16;
    logic signed [15:0] applied_delta;
    logic               spike_rejected;
  } out_word_t;

  // configuration register indexes
  localparam logic [1:0] REG_NOISE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_INVERT_PHASE    = 2'd1;
  localparam logic [1:0] REG_COUNTS_PER_REV  = 2'd2;
  localparam logic [1:0] REG_RPM_ALPHA       = 2'd3;

  localparam int CFG_DATA_W = 17;

  // register reset values
  localparam logic [14:0] NOISE_THRESHOLD_RST = 15'd2000;
  localparam logic [15:0] COUNTS_PER_REV_RST  = 16'd4096;
  localparam logic [16:0] RPM_ALPHA_RST       = 17'd6554;
  localparam logic [16:0] ALPHA_ONE           = 17'd65536;

  // scale factors: 360 * 256 for degrees Q.8, 60e6 us per minute
  localparam logic [16:0] DEG_SCALE = 17'd92160;
  localparam logic [25:0] RPM_SCALE = 26'd60000000;

  // shared divider geometry
  localparam int DIV_NUM_W     = 57;
  localparam int DIV_DEN_W     = 36;
  localparam int POS_DIV_STEPS = 49;
  localparam int RPM_DIV_STEPS = 57;

  // 48-bit saturation limits, as magnitudes and as results
  localparam logic [56:0] MAG_MAX_POS = 57'd140737488355327;
  localparam logic [56:0] MAG_MAX_NEG = 57'd140737488355328;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_POS_LOAD,
    S_POS_DIV,
    S_POS_DONE,
    S_RPM_DIV,
    S_RPM_DONE,
    S_FILT_LO,
    S_FILT_HI,
    S_FILT_SUM,
    S_OUT
  } state_t;

endpackage

>>> src/quadrature_count_tracker_rpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_count_tracker_rpm: encoder position and filtered speed tracker
// Folds raw counter changes into a signed delta, rejects spikes, accumulates
// the position count and derives degrees Q.8 and IIR-filtered RPM Q32.16.
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_ready / in_data) takes one word per sample:
//   raw counter value and microseconds since the previous sample
//   out channel (out_valid / out_ready / out_data) returns one word per
//   sample: total count, degrees, filtered rpm, applied delta, spike flag
//   cfg port writes one register per cycle while cfg_wr_en is high
//   one word is in work at a time: a new word is taken only once the
//   previous one has left the final state
//   the sequence runs the delta, divider setup and the shared restoring
//   divider: 49 steps for degrees and 57 steps for rpm, one quotient bit
//   per cycle, then the two partial products of the filter multiply
//   the result sits in an output register; a stalled receiver does not stop
//   the next input word, which waits in the final state until that register
//   frees up
//   reset clears the last raw value, count and filter, and loads register
//   defaults (threshold 2000, no inversion, 4096 counts, alpha 6554)
// ----------------------------------------------------------------------------
module quadrature_count_tracker_rpm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qct_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output qct_pkg::out_word_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_addr,
  input  logic [qct_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  // configuration registers
  logic [14:0] noise_threshold;
  logic        invert_phase;
  logic [15:0] counts_per_rev;
  logic [16:0] rpm_alpha;

  // tracker state
  logic [15:0]        last_raw;
  logic [31:0]        count_accum;
  logic signed [47:0] rpm_filter;

  // sample and step results
  logic [15:0]        raw_q;
  logic [19:0]        dt_q;
  logic signed [15:0] applied_q;
  logic               spike_q;
  logic signed [47:0] pos_q;
  logic signed [48:0] diff_q;
  logic signed [43:0] prod_lo;
  logic signed [43:0] prod_hi;

  // shared divider
  logic [qct_pkg::DIV_NUM_W-1:0] num_reg;
  logic [qct_pkg::DIV_DEN_W-1:0] den_reg;
  logic [qct_pkg::DIV_DEN_W-1:0] rem_reg;
  logic [5:0]                    step_cnt;
  logic                          div_neg;

  qct_pkg::state_t   state, state_next;
  qct_pkg::out_word_t out_reg;
  logic              out_free;

  // signed saturation of a sign and magnitude quotient to 48 bits
  function automatic logic signed [47:0] sat48(input logic neg,
                                               input logic [56:0] mag);
    logic signed [47:0] res;
    if (neg) begin
      if (mag > qct_pkg::MAG_MAX_NEG) res = qct_pkg::MIN48;
      else res = -$signed(mag[47:0]);
    end else begin
      if (mag > qct_pkg::MAG_MAX_POS) res = qct_pkg::MAX48;
      else res = $signed(mag[47:0]);
    end
    return res;
  endfunction

  // effective operands: zero counts and zero time read as one, alpha clamps
  logic [15:0] cpr_eff;
  logic [19:0] dt_eff;
  logic [16:0] alpha_eff;
  assign cpr_eff   = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;
  assign dt_eff    = (dt_q == 20'd0) ? 20'd1 : dt_q;
  assign alpha_eff = (rpm_alpha > qct_pkg::ALPHA_ONE) ? qct_pkg::ALPHA_ONE : rpm_alpha;

  // delta with rollover folded, spike check and inversion
  logic signed [15:0] delta;
  logic [16:0]        delta_mag;
  logic               spike;
  logic signed [15:0] applied;
  assign delta     = $signed(raw_q - last_raw);
  assign delta_mag = delta[15] ? (17'd0 - {delta[15], delta}) : {1'b0, delta};
  assign spike     = delta_mag > {2'b00, noise_threshold};
  assign applied   = spike ? 16'sd0 : (invert_phase ? -delta : delta);

  // position numerator: |count| * 360 * 256
  logic        count_neg;
  logic [31:0] count_mag;
  logic [48:0] pos_num;
  assign count_neg = count_accum[31];
  assign count_mag = count_neg ? (32'd0 - count_accum) : count_accum;
  assign pos_num   = count_mag * qct_pkg::DEG_SCALE;

  // speed numerator |delta| * 60e6 and denominator cpr * dt
  logic [14:0] delta_abs;
  logic [40:0] rpm_num;
  logic [35:0] rpm_den;
  assign delta_abs = applied_q[15] ? 15'(16'd0 - applied_q) : applied_q[14:0];
  assign rpm_num   = delta_abs * qct_pkg::RPM_SCALE;
  assign rpm_den   = cpr_eff * dt_eff;

  // divider step: shift in one numerator bit, trial subtract
  logic [36:0] rem_sh;
  logic [37:0] trial;
  logic        trial_ge;
  assign rem_sh   = {rem_reg, num_reg[qct_pkg::DIV_NUM_W-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, den_reg};
  assign trial_ge = ~trial[37];

  // filter multiplier shared by the two partial products of alpha * diff
  logic signed [17:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [43:0] mul_p;
  assign mul_a = $signed({1'b0, alpha_eff});
  assign mul_b = (state == qct_pkg::S_FILT_LO) ? $signed({1'b0, diff_q[24:0]})
                                                : 26'($signed(diff_q[48:25]));
  assign mul_p = mul_a * mul_b;

  // recombine partial products, floor divide by 65536 and add to filter
  logic [63:0] filt_sum;
  assign filt_sum = ({{20{prod_hi[43]}}, prod_hi} << 25) + {{20{prod_lo[43]}}, prod_lo};

  assign out_free = !out_valid || out_ready;
  assign out_data = out_reg;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      qct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = qct_pkg::S_DELTA;
      end
      qct_pkg::S_DELTA:    state_next = qct_pkg::S_POS_LOAD;
      qct_pkg::S_POS_LOAD: state_next = qct_pkg::S_POS_DIV;
      qct_pkg::S_POS_DIV: begin
        if (step_cnt == 6'd0) state_next = qct_pkg::S_POS_DONE;
      end
      qct_pkg::S_POS_DONE: state_next = qct_pkg::S_RPM_DIV;
      qct_pkg::S_RPM_DIV: begin
        if (step_cnt == 6'd0) state_next = qct_pkg::S_RPM_DONE;
      end
      qct_pkg::S_RPM_DONE: state_next = qct_pkg::S_FILT_LO;
      qct_pkg::S_FILT_LO:  state_next = qct_pkg::S_FILT_HI;
      qct_pkg::S_FILT_HI:  state_next = qct_pkg::S_FILT_SUM;
      qct_pkg::S_FILT_SUM: state_next = qct_pkg::S_OUT;
      qct_pkg::S_OUT: begin
        if (out_free) state_next = qct_pkg::S_IDLE;
      end
      default: state_next = qct_pkg::S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_threshold <= qct_pkg::NOISE_THRESHOLD_RST;
      invert_phase    <= 1'b0;
      counts_per_rev  <= qct_pkg::COUNTS_PER_REV_RST;
      rpm_alpha       <= qct_pkg::RPM_ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        qct_pkg::REG_NOISE_THRESHOLD: noise_threshold <= cfg_wr_data[14:0];
        qct_pkg::REG_INVERT_PHASE:    invert_phase    <= cfg_wr_data[0];
        qct_pkg::REG_COUNTS_PER_REV:  counts_per_rev  <= cfg_wr_data[15:0];
        qct_pkg::REG_RPM_ALPHA:       rpm_alpha       <= cfg_wr_data[16:0];
        default: ;
      endcase
    end
  end

  // tracker state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw    <= '0;
      count_accum <= '0;
      rpm_filter  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == qct_pkg::S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == qct_pkg::S_DELTA) begin
        last_raw    <= raw_q;
        count_accum <= count_accum + {{16{applied[15]}}, applied};
      end
      if (state == qct_pkg::S_FILT_SUM) rpm_filter <= rpm_filter + $signed(filt_sum[63:16]);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      qct_pkg::S_IDLE: begin
        raw_q <= in_data.raw_count;
        dt_q  <= in_data.dt_us;
      end
      qct_pkg::S_DELTA: begin
        applied_q <= applied;
        spike_q   <= spike;
      end
      qct_pkg::S_POS_LOAD: begin
        num_reg  <= {pos_num, 8'd0};
        den_reg  <= {20'd0, cpr_eff};
        rem_reg  <= '0;
        step_cnt <= 6'(qct_pkg::POS_DIV_STEPS - 1);
        div_neg  <= count_neg;
      end
      qct_pkg::S_POS_DIV, qct_pkg::S_RPM_DIV: begin
        num_reg  <= {num_reg[qct_pkg::DIV_NUM_W-2:0], trial_ge};
        rem_reg  <= trial_ge ? trial[35:0] : rem_sh[35:0];
        step_cnt <= step_cnt - 6'd1;
      end
      qct_pkg::S_POS_DONE: begin
        pos_q    <= sat48(div_neg, num_reg);
        num_reg  <= {rpm_num, 16'd0};
        den_reg  <= rpm_den;
        rem_reg  <= '0;
        step_cnt <= 6'(qct_pkg::RPM_DIV_STEPS - 1);
        div_neg  <= applied_q[15];
      end
      qct_pkg::S_RPM_DONE: begin
        diff_q <= 49'(sat48(div_neg, num_reg)) - 49'(rpm_filter);
      end
      qct_pkg::S_FILT_LO: prod_lo <= mul_p;
      qct_pkg::S_FILT_HI: prod_hi <= mul_p;
      qct_pkg::S_FILT_SUM: ;
      qct_pkg::S_OUT: begin
        if (out_free) begin
          out_reg.total_count     <= $signed(count_accum);
          out_reg.position_deg_q8 <= pos_q;
          out_reg.rpm_q16         <= rpm_filter;
          out_reg.applied_delta   <= applied_q;
          out_reg.spike_rejected  <= spike_q;
        end
      end
      default: ;
    endcase
  end

endmodule
